[hdl/gsq_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and LFSR helper functions for the Gold sequence QPSK core.
// Depends on nothing; used by the front, queue, back and top-level modules.
package gsq_pkg;

    localparam int LFSR_W = 31;
    localparam int SC_W   = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

    typedef logic [LFSR_W-1:0] t_lfsr;
    typedef logic [LFSR_W-1:0][LFSR_W-1:0] t_jump_matrix;

    typedef struct packed {
        t_func func;
        t_lfsr x2_init;
    } t_item;

    function automatic t_lfsr x1_step(input t_lfsr s);
        return {s[0] ^ s[3], s[LFSR_W-1:1]};
    endfunction

    function automatic t_lfsr x2_step(input t_lfsr s);
        return {s[0] ^ s[1] ^ s[2] ^ s[3], s[LFSR_W-1:1]};
    endfunction

    function automatic t_lfsr x1_advance(input t_lfsr s, input int n);
        t_lfsr v;
        v = s;
        for (int k = 0; k < n; k++) begin
            v = x1_step(v);
        end
        return v;
    endfunction

    function automatic t_lfsr x2_advance(input t_lfsr s, input int n);
        t_lfsr v;
        v = s;
        for (int k = 0; k < n; k++) begin
            v = x2_step(v);
        end
        return v;
    endfunction

    // Column j holds the x2 state reached from a lone one in bit j after n steps.
    function automatic t_jump_matrix x2_jump_matrix(input int n);
        t_jump_matrix mtx;
        t_lfsr unit;
        for (int j = 0; j < LFSR_W; j++) begin
            unit = '0;
            unit[j] = 1'b1;
            mtx[j] = x2_advance(unit, n);
        end
        return mtx;
    endfunction

endpackage

[hdl/gsq_front.sv]
`timescale 1ns / 1ps
// Front pipeline: accepts items, forms c_init for each item and jumps x2 ahead.
// Depends on gsq_pkg; feeds gsq_queue.
module gsq_front #(
    parameter int SKIP_OFFSET = 1600
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [7:0]         i_frame_index,
    input  logic [7:0]         i_symbol_index,
    input  logic [15:0]        i_cell_identity,
    input  logic [1:0]         i_cp_type,
    output logic               o_push,
    output gsq_pkg::t_item     o_item,
    input  logic               i_full
);

    localparam gsq_pkg::t_jump_matrix JUMP = gsq_pkg::x2_jump_matrix(SKIP_OFFSET);

    logic                 r_v1, r_v2, r_v3;
    gsq_pkg::t_func       r_func1, r_func2, r_func3;
    logic [21:0]          r_prod;
    logic [17:0]          r_low;
    gsq_pkg::t_lfsr       r_cinit;
    gsq_pkg::t_lfsr       r_x2j;

    logic                 adv;
    logic [12:0]          term_a;
    logic [21:0]          term_b;
    logic [31:0]          cinit_sum;
    gsq_pkg::t_lfsr       n_x2j;

    assign adv     = !(r_v3 && i_full);
    assign o_ready = adv;
    assign o_push  = r_v3 && !i_full;
    assign o_item  = '{func: r_func3, x2_init: r_x2j};

    assign term_a    = 13'd15 * (13'(i_frame_index) + 13'd1) + 13'(i_symbol_index) + 13'd1;
    assign term_b    = {4'b0, i_cell_identity, 2'b01};
    assign cinit_sum = {r_prod, 10'b0} + {14'b0, r_low};

    always_comb begin
        n_x2j = '0;
        for (int j = 0; j < gsq_pkg::LFSR_W; j++) begin
            if (r_cinit[j]) begin
                n_x2j = n_x2j ^ JUMP[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_func1 <= gsq_pkg::t_func'(i_func);
            r_prod  <= 22'(22'(term_a) * term_b);
            r_low   <= {i_cell_identity, i_cp_type};
            r_func2 <= r_func1;
            r_cinit <= cinit_sum[gsq_pkg::LFSR_W-1:0];
            r_func3 <= r_func2;
            r_x2j   <= n_x2j;
        end
    end

endmodule

[hdl/gsq_queue.sv]
`timescale 1ns / 1ps
// Short FIFO that decouples the front pipeline from the sequence generator.
// Depends on gsq_pkg.
module gsq_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gsq_pkg::t_item     i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output gsq_pkg::t_item     o_item
);

    gsq_pkg::t_item                  r_mem [gsq_pkg::QUEUE_DEPTH];
    logic [gsq_pkg::QPTR_W-1:0]      r_wr, r_rd;
    logic [gsq_pkg::QPTR_W:0]        r_count;

    assign o_full  = (r_count == (gsq_pkg::QPTR_W+1)'(gsq_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[hdl/gsq_back.sv]
`timescale 1ns / 1ps
// Sequence generator: holds both LFSRs and the subcarrier counter, drives the output register.
// Depends on gsq_pkg; pops items from gsq_queue.
module gsq_back #(
    parameter int SUBCARRIER_COUNT = 161,
    parameter int DC_INDEX         = 80,
    parameter int SKIP_OFFSET      = 1600
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_head_valid,
    input  gsq_pkg::t_item               i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_i_bit,
    output logic                         o_q_bit,
    output logic                         o_is_dc,
    output logic [gsq_pkg::SC_W-1:0]     o_subcarrier_index,
    output logic                         o_last
);

    localparam gsq_pkg::t_lfsr X1_START = gsq_pkg::x1_advance(31'd1, SKIP_OFFSET);
    localparam logic [gsq_pkg::SC_W-1:0] LAST_IDX = gsq_pkg::SC_W'(SUBCARRIER_COUNT - 1);
    localparam logic [gsq_pkg::SC_W-1:0] DC_IDX   = gsq_pkg::SC_W'(DC_INDEX);

    gsq_pkg::t_lfsr               r_x1, r_x2;
    logic [gsq_pkg::SC_W-1:0]     r_m;
    logic                         r_active;
    logic                         r_o_valid;
    logic                         r_i_bit, r_q_bit, r_is_dc, r_last;
    logic [gsq_pkg::SC_W-1:0]     r_sc;

    logic                         is_dc, is_last;

    assign o_pop   = i_head_valid && (!r_o_valid || i_ready);
    assign is_dc   = (r_m == DC_IDX);
    assign is_last = (r_m == LAST_IDX);

    assign o_valid            = r_o_valid;
    assign o_i_bit            = r_i_bit;
    assign o_q_bit            = r_q_bit;
    assign o_is_dc            = r_is_dc;
    assign o_subcarrier_index = r_sc;
    assign o_last             = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1      <= 31'd1;
            r_x2      <= '0;
            r_m       <= '0;
            r_active  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (o_pop) begin
                case (i_head.func)
                    gsq_pkg::FUNC_START: begin
                        r_x1     <= X1_START;
                        r_x2     <= i_head.x2_init;
                        r_m      <= '0;
                        r_active <= 1'b1;
                    end
                    gsq_pkg::FUNC_STEP: begin
                        if (r_active) begin
                            r_x1      <= gsq_pkg::x1_step(gsq_pkg::x1_step(r_x1));
                            r_x2      <= gsq_pkg::x2_step(gsq_pkg::x2_step(r_x2));
                            r_o_valid <= 1'b1;
                            r_i_bit   <= (r_x1[0] ^ r_x2[0]) && !is_dc;
                            r_q_bit   <= (r_x1[1] ^ r_x2[1]) && !is_dc;
                            r_is_dc   <= is_dc;
                            r_sc      <= r_m;
                            r_last    <= is_last;
                            if (is_last) begin
                                r_active <= 1'b0;
                                r_m      <= '0;
                            end else begin
                                r_m <= r_m + 1'b1;
                            end
                        end
                    end
                    default: begin
                        r_active <= r_active;
                    end
                endcase
            end
        end
    end

endmodule

[hdl/gold_sequence_qpsk_reference_core.sv]
`timescale 1ns / 1ps
// Top level of the Gold sequence QPSK reference generator with its register port.
// Depends on gsq_pkg, gsq_front, gsq_queue and gsq_back.
//
// Usage: program cell_identity (address 0) and cp_type (address 4) over the APB
// port while the block is idle. Each input transaction carries func, frame_index
// and symbol_index. A start transaction (func 0) seeds the Gold sequence for a
// symbol and gives no result; each step transaction (func 1) then gives one result
// transaction with the QPSK sign bits, the DC flag, the subcarrier index and a last
// mark. Steps before a start or after the last subcarrier are dropped silently.
// Throughput is one transaction per cycle in both directions while the receiver
// keeps ready high. A step passes through three front stages (multiplier, c_init
// adder, jump matrix), then the queue and then the output register before its
// result is presented. The jump over the skip offset is a constant matrix, so a
// start passes through the same stages as a step. When the receiver stalls, the
// output register holds its result, the four-entry queue fills behind it, and then
// the input ready falls. Reset clears the queue, the pipeline, the registers and the
// sequence state; the block is idle afterwards.
module gold_sequence_qpsk_reference_core #(
    parameter int SUBCARRIER_COUNT = 161,
    parameter int DC_INDEX         = 80,
    parameter int SKIP_OFFSET      = 1600
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_frame_index,
    input  logic [7:0]  i_symbol_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_i_bit,
    output logic        o_q_bit,
    output logic        o_is_dc,
    output logic [9:0]  o_subcarrier_index,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_CELL_ID = 1'b0;
    localparam logic REG_CP_TYPE = 1'b1;
    localparam logic [9:0] LAST_IDX = 10'(SUBCARRIER_COUNT - 1);

    logic [15:0]     r_cell_identity;
    logic [1:0]      r_cp_type;
    logic            cfg_wr;
    logic            push, full, pop, head_valid;
    gsq_pkg::t_item  push_item, head_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_identity <= '0;
            r_cp_type       <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_CELL_ID: r_cell_identity <= pwdata[15:0];
                REG_CP_TYPE: r_cp_type       <= pwdata[1:0];
                default:     r_cp_type       <= r_cp_type;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CELL_ID: prdata = {16'b0, r_cell_identity};
            REG_CP_TYPE: prdata = {30'b0, r_cp_type};
            default:     prdata = '0;
        endcase
    end

    gsq_front #(
        .SKIP_OFFSET(SKIP_OFFSET)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_frame_index  (i_frame_index),
        .i_symbol_index (i_symbol_index),
        .i_cell_identity(r_cell_identity),
        .i_cp_type      (r_cp_type),
        .o_push         (push),
        .o_item         (push_item),
        .i_full         (full)
    );

    gsq_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(head_valid),
        .o_item (head_item)
    );

    gsq_back #(
        .SUBCARRIER_COUNT(SUBCARRIER_COUNT),
        .DC_INDEX        (DC_INDEX),
        .SKIP_OFFSET     (SKIP_OFFSET)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head_valid      (head_valid),
        .i_head            (head_item),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_i_bit           (o_i_bit),
        .o_q_bit           (o_q_bit),
        .o_is_dc           (o_is_dc),
        .o_subcarrier_index(o_subcarrier_index),
        .o_last            (o_last)
    );

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_subcarrier_index <= LAST_IDX))
        else $error("subcarrier index beyond the last subcarrier");

    a_dc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_dc) |-> (!o_i_bit && !o_q_bit))
        else $error("DC subcarrier carries nonzero sign bits");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_subcarrier_index == LAST_IDX)))
        else $error("last mark does not match the final subcarrier");

endmodule

[sim/gold_sequence_qpsk_reference_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for gold_sequence_qpsk_reference_core: start and step
// transactions under random idling, with every subcarrier result predicted and checked.
// Depends on gsq_pkg and the core RTL.
module gold_sequence_qpsk_reference_core_tb;

    localparam int SC_COUNT      = 161;
    localparam int DC_POS        = 80;
    localparam int NC_SKIP       = 1600;
    localparam int PHASE_BUDGET  = 190;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 500000;
    localparam logic [2:0] ADDR_CELL_ID = 3'd0;
    localparam logic [2:0] ADDR_CP_TYPE = 3'd4;

    typedef struct {
        gsq_pkg::t_func func;
        logic [7:0]     frame;
        logic [7:0]     symbol;
    } t_symbol_cmd;

    typedef struct {
        logic       i_bit;
        logic       q_bit;
        logic       is_dc;
        logic [9:0] sc;
        logic       last;
    } t_subcarrier;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_func = 1'b0;
    logic [7:0]  i_frame_index = '0;
    logic [7:0]  i_symbol_index = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_i_bit;
    logic        o_q_bit;
    logic        o_is_dc;
    logic [9:0]  o_subcarrier_index;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_symbol_cmd pending_cmds[$];
    t_subcarrier expected_subcarriers[$];

    logic [30:0] lfsr_x1 = 31'd1;
    logic [30:0] lfsr_x2 = '0;
    logic [9:0]  model_next_sc = '0;
    logic        model_running = 1'b0;
    logic [15:0] model_cell_id = '0;
    logic [1:0]  model_cp = '0;

    int errors = 0;
    int results_checked = 0;
    int starts_seen = 0;
    int settings_used = 1;
    int cycle_count = 0;
    int send_idle_pct = 20;
    int stall_pct = 20;
    int send_gap = 0;
    int stall_left = 0;

    gold_sequence_qpsk_reference_core DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic gold_shift();
        logic c;
        c = lfsr_x1[0] ^ lfsr_x2[0];
        lfsr_x1 = {lfsr_x1[0] ^ lfsr_x1[3], lfsr_x1[30:1]};
        lfsr_x2 = {lfsr_x2[0] ^ lfsr_x2[1] ^ lfsr_x2[2] ^ lfsr_x2[3], lfsr_x2[30:1]};
        return c;
    endfunction

    task automatic predict_transaction(input logic func, input logic [7:0] frame,
                                       input logic [7:0] symbol);
        int unsigned term_a;
        int unsigned term_b;
        int unsigned seed;
        t_subcarrier res;
        if (func == gsq_pkg::FUNC_START) begin
            term_a = 15 * (int'(frame) + 1) + int'(symbol) + 1;
            term_b = 4 * int'(model_cell_id) + 1;
            seed = 1024 * term_a * term_b + 4 * int'(model_cell_id) + int'(model_cp);
            lfsr_x1 = 31'd1;
            lfsr_x2 = seed[30:0];
            repeat (NC_SKIP) void'(gold_shift());
            model_next_sc = '0;
            model_running = 1'b1;
            starts_seen++;
        end else if (model_running) begin
            res.sc = model_next_sc;
            res.i_bit = gold_shift();
            res.q_bit = gold_shift();
            res.is_dc = (model_next_sc == DC_POS);
            res.last = (model_next_sc == SC_COUNT - 1);
            if (res.is_dc) begin
                res.i_bit = 1'b0;
                res.q_bit = 1'b0;
            end
            expected_subcarriers.push_back(res);
            if (res.last) begin
                model_running = 1'b0;
                model_next_sc = '0;
            end else begin
                model_next_sc = model_next_sc + 10'd1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [9:0] want,
                               input logic [9:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_symbol_cmd cmd;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_transaction(i_func, i_frame_index, i_symbol_index);
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cmd = pending_cmds.pop_front();
                    i_valid <= 1'b1;
                    i_func <= cmd.func;
                    i_frame_index <= cmd.frame;
                    i_symbol_index <= cmd.symbol;
                    if ($urandom_range(0, 99) < send_idle_pct) begin
                        send_gap = $urandom_range(1, 15);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_subcarrier want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_subcarriers.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual subcarrier %0d",
                             $time, o_subcarrier_index);
                end else begin
                    want = expected_subcarriers.pop_front();
                    check_field("i_bit", want.i_bit, o_i_bit);
                    check_field("q_bit", want.q_bit, o_q_bit);
                    check_field("is_dc", want.is_dc, o_is_dc);
                    check_field("subcarrier_index", want.sc, o_subcarrier_index);
                    check_field("last", want.last, o_last);
                    results_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 14);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic push_cmd(input gsq_pkg::t_func func, input logic [7:0] frame,
                            input logic [7:0] symbol);
        t_symbol_cmd cmd;
        cmd.func = func;
        cmd.frame = frame;
        cmd.symbol = symbol;
        pending_cmds.push_back(cmd);
    endtask

    function automatic logic [7:0] pick_index();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_step();
        push_cmd(gsq_pkg::FUNC_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic fill_phase(input int budget);
        int counted;
        int steps;
        counted = 0;
        while (counted < budget) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    push_cmd(gsq_pkg::FUNC_START, pick_index(), pick_index());
                    repeat (SC_COUNT) push_step();
                    repeat ($urandom_range(0, 3)) push_step();
                    counted += 1 + SC_COUNT;
                end
                7, 8: begin
                    steps = $urandom_range(1, 60);
                    push_cmd(gsq_pkg::FUNC_START, pick_index(), pick_index());
                    repeat (steps) push_step();
                    counted += 1 + steps;
                end
                default: begin
                    repeat ($urandom_range(1, 8)) begin
                        push_cmd(gsq_pkg::t_func'($urandom_range(0, 1)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    end
                    counted += 1;
                end
            endcase
        end
    endtask

    task automatic drain_all();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_valid || expected_subcarriers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== value) begin
            errors++;
            $display("%0t: readback at %0d, expected %0h actual %0h", $time, addr, value, prdata);
        end
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int unsigned cell_ids[5];
        int unsigned cp_types[5];
        int idle_mix[5];
        int stall_mix[5];
        cell_ids = '{65535, 0, 1, $urandom_range(0, 65535), 32768};
        cp_types = '{3, 0, 1, $urandom_range(0, 3), 2};
        idle_mix = '{20, 0, 40, 10, 0};
        stall_mix = '{20, 0, 10, 40, 0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Steps before any start must be dropped; starts also restart a running symbol.
        push_cmd(gsq_pkg::FUNC_STEP, 8'hA5, 8'h5A);
        push_cmd(gsq_pkg::FUNC_STEP, 8'h00, 8'hFF);
        push_cmd(gsq_pkg::FUNC_START, 8'd0, 8'd0);
        repeat (3) push_step();
        push_cmd(gsq_pkg::FUNC_START, 8'd255, 8'd255);
        repeat (2) push_step();
        push_cmd(gsq_pkg::FUNC_START, 8'd255, 8'd0);
        push_step();
        push_cmd(gsq_pkg::FUNC_START, 8'd0, 8'd255);
        push_step();
        drain_all();

        for (int p = 0; p < 5; p++) begin
            program_reg(ADDR_CELL_ID, cell_ids[p]);
            program_reg(ADDR_CP_TYPE, cp_types[p]);
            model_cell_id = cell_ids[p][15:0];
            model_cp = cp_types[p][1:0];
            settings_used++;
            send_idle_pct = idle_mix[p];
            stall_pct = stall_mix[p];
            fill_phase(PHASE_BUDGET);
            drain_all();
        end

        $display("Checked %0d subcarrier results after %0d sequence starts.",
                 results_checked, starts_seen);
        $display("Register settings used: %0d, including both extremes of each field.",
                 settings_used);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
